/* sv/cbpg_pkg.sv */
// Shared types, constants and tables for the circle boundary point generator.
package cbpg_pkg;

	localparam int unsigned MAX_PER_QUARTER_DEF = 1024;
	localparam int unsigned CORDIC_STAGES_DEF   = 24;

	localparam int unsigned QUAD_W    = 2;
	localparam int unsigned IDX_W     = 10;
	localparam int unsigned STEP_W    = 32;
	localparam int unsigned PPQ_W     = 11;
	localparam int unsigned COORD_W   = 32;
	localparam int unsigned RAD_W     = 31;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;

	// angle product and its reduction modulo 2*pi
	localparam int unsigned PROD_W    = IDX_W + STEP_W;
	localparam int unsigned RED_STEPS = IDX_W;
	localparam int unsigned ANG_W     = 34;

	localparam logic [PROD_W-1:0]       TWO_PI_RED  = 42'd6746518852;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
	localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	// CORDIC datapath
	localparam int unsigned CW = 34;
	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam int unsigned ATAN_ENTRIES = 30;
	localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
		32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
		32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
		32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
		32'd1023,      32'd511,       32'd255,       32'd127,       32'd63,
		32'd31,        32'd15,        32'd8,         32'd4,         32'd2
	};

	// scaling
	localparam int unsigned TRIG_W = 32;
	localparam int unsigned MUL_W  = 64;
	localparam int unsigned TERM_W = 34;
	localparam int unsigned SUM_W  = 35;

	// stages outside the CORDIC: product, reduction, two fold stages, four scale stages
	localparam int unsigned FIXED_LAT = 1 + RED_STEPS + 2 + 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X = 3'd0,
		CFG_ORIGIN_Y = 3'd1,
		CFG_RADIUS   = 3'd2,
		CFG_ANG_INC  = 3'd3,
		CFG_PPQ      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic              vld;
		logic [QUAD_W-1:0] quad;
		logic              err;
		logic              neg;
	} ctl_t;

endpackage

/* sv/circle_boundary_point_generator_top.sv */
// Top level of the circle boundary point generator: config registers and pipeline.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  command  | start / busy         | quadrant, step_index
//  result   | done (one-cycle)     | point_x, point_y, index_error
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One transaction enters per cycle; busy is never raised.
// The pipeline runs a product stage, the reduction stages, the fold stages,
// CORDIC_STAGES micro-rotations and 4 scale/offset stages.
// Reset clears valid bits and config registers (points_per_quarter to 1).
// Results are strobed on done for one cycle and cannot be held off.
module circle_boundary_point_generator_top #(
	parameter int unsigned MAX_PER_QUARTER = cbpg_pkg::MAX_PER_QUARTER_DEF,
	parameter int unsigned CORDIC_STAGES   = cbpg_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [cbpg_pkg::QUAD_W-1:0]         quadrant,
	input  logic [cbpg_pkg::IDX_W-1:0]          step_index,
	output logic                                done,
	output logic signed [cbpg_pkg::COORD_W-1:0] point_x,
	output logic signed [cbpg_pkg::COORD_W-1:0] point_y,
	output logic                                index_error,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cbpg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cbpg_pkg::CFG_DAT_W-1:0]      cfg_data
);
	import cbpg_pkg::*;

	localparam int unsigned MAX_W = $clog2(MAX_PER_QUARTER + 1);
	localparam int unsigned LIM_W = (MAX_W > PPQ_W) ? MAX_W : PPQ_W;
	localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(MAX_PER_QUARTER);

	logic signed [COORD_W-1:0] origin_x_q;
	logic signed [COORD_W-1:0] origin_y_q;
	logic [RAD_W-1:0]          radius_q;
	logic [STEP_W-1:0]         ang_inc_q;
	logic [PPQ_W-1:0]          ppq_q;

	logic [LIM_W-1:0]     ppq_ext;
	logic [LIM_W-1:0]     limit;
	ctl_t                 ctl_in, ctl_ang, ctl_cor, ctl_out;
	logic signed [CW-1:0] angle;
	logic signed [CW-1:0] cos_v, sin_v;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			radius_q   <= '0;
			ang_inc_q  <= '0;
			ppq_q      <= PPQ_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ORIGIN_X: origin_x_q <= $signed(cfg_data[COORD_W-1:0]);
				CFG_ORIGIN_Y: origin_y_q <= $signed(cfg_data[COORD_W-1:0]);
				CFG_RADIUS:   radius_q   <= cfg_data[RAD_W-1:0];
				CFG_ANG_INC:  ang_inc_q  <= cfg_data[STEP_W-1:0];
				CFG_PPQ:      ppq_q      <= cfg_data[PPQ_W-1:0];
				default: ;
			endcase
		end
	end

	assign ppq_ext = LIM_W'(ppq_q);
	assign limit   = (ppq_ext > LIM_MAX) ? LIM_MAX : ppq_ext;

	always_comb begin
		ctl_in.vld  = start && !busy;
		ctl_in.quad = quadrant;
		ctl_in.err  = (LIM_W'(step_index) >= limit);
		ctl_in.neg  = 1'b0;
	end

	cbpg_angle u_angle (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_in     (ctl_in),
		.step_index (step_index),
		.ang_inc    (ang_inc_q),
		.ctl_out    (ctl_ang),
		.angle      (angle)
	);

	cbpg_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_ang),
		.angle   (angle),
		.ctl_out (ctl_cor),
		.cos_out (cos_v),
		.sin_out (sin_v)
	);

	cbpg_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_cor),
		.cos_in   (cos_v),
		.sin_in   (sin_v),
		.origin_x (origin_x_q),
		.origin_y (origin_y_q),
		.radius   (radius_q),
		.ctl_out  (ctl_out),
		.point_x  (point_x),
		.point_y  (point_y)
	);

	assign done        = ctl_out.vld;
	assign index_error = ctl_out.err;

endmodule

/* sv/cbpg_angle.sv */
// Angle product, modulo 2*pi reduction and fold into [-pi/2, pi/2].
module cbpg_angle (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cbpg_pkg::ctl_t                 ctl_in,
	input  logic [cbpg_pkg::IDX_W-1:0]     step_index,
	input  logic [cbpg_pkg::STEP_W-1:0]    ang_inc,
	output cbpg_pkg::ctl_t                 ctl_out,
	output logic signed [cbpg_pkg::CW-1:0] angle
);
	import cbpg_pkg::*;

	logic [PROD_W-1:0] rem_s [RED_STEPS+1];
	ctl_t              rctl_s [RED_STEPS+1];

	logic signed [ANG_W-1:0] a_f1_s;
	ctl_t                    ctl_f1_s;
	logic signed [ANG_W-1:0] a_f2_s;
	ctl_t                    ctl_f2_s;

	logic signed [ANG_W-1:0] rem_a;
	logic signed [ANG_W-1:0] fold_a;
	logic                    fold_neg;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rctl_s[0] <= '0;
		end else begin
			rctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= PROD_W'(step_index) * PROD_W'(ang_inc);
	end

	// restoring reduction, one quotient bit per stage
	for (genvar k = 1; k <= RED_STEPS; k++) begin : g_red
		localparam logic [PROD_W-1:0] SUB = TWO_PI_RED << (RED_STEPS - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rctl_s[k] <= '0;
			end else begin
				rctl_s[k] <= rctl_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rem_s[k-1] >= SUB) begin
				rem_s[k] <= rem_s[k-1] - SUB;
			end else begin
				rem_s[k] <= rem_s[k-1];
			end
		end
	end

	assign rem_a = $signed(rem_s[RED_STEPS][ANG_W-1:0]);

	always_comb begin
		fold_a   = a_f1_s;
		fold_neg = 1'b0;
		priority if (a_f1_s > HALF_PI_Q30) begin
			fold_a   = PI_Q30 - a_f1_s;
			fold_neg = 1'b1;
		end else if (a_f1_s < -HALF_PI_Q30) begin
			fold_a   = -PI_Q30 - a_f1_s;
			fold_neg = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_f1_s <= '0;
			ctl_f2_s <= '0;
		end else begin
			ctl_f1_s <= rctl_s[RED_STEPS];
			ctl_f2_s <= {ctl_f1_s.vld, ctl_f1_s.quad, ctl_f1_s.err, fold_neg};
		end
	end

	always_ff @(posedge clk) begin
		a_f1_s <= (rem_a > PI_Q30) ? (rem_a - TWO_PI_Q30) : rem_a;
		a_f2_s <= fold_a;
	end

	assign ctl_out = ctl_f2_s;
	assign angle   = CW'(a_f2_s);

endmodule

/* sv/cbpg_cordic.sv */
// Rotation-mode CORDIC pipeline, one micro-rotation per stage.
module cbpg_cordic #(
	parameter int unsigned STAGES = cbpg_pkg::CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cbpg_pkg::ctl_t                 ctl_in,
	input  logic signed [cbpg_pkg::CW-1:0] angle,
	output cbpg_pkg::ctl_t                 ctl_out,
	output logic signed [cbpg_pkg::CW-1:0] cos_out,
	output logic signed [cbpg_pkg::CW-1:0] sin_out
);
	import cbpg_pkg::*;

	logic signed [CW-1:0] x_s [STAGES];
	logic signed [CW-1:0] y_s [STAGES];
	logic signed [CW-1:0] z_s [STAGES];
	ctl_t                 c_s [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [CW-1:0] xi;
		logic signed [CW-1:0] yi;
		logic signed [CW-1:0] zi;
		ctl_t                 ci;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] at;

		if (i == 0) begin : g_first
			assign xi = GAIN_Q30;
			assign yi = '0;
			assign zi = angle;
			assign ci = ctl_in;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign ci = c_s[i-1];
		end

		assign dx = yi >>> i;
		assign dy = xi >>> i;
		assign at = CW'(ATAN_Q30[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_s[i] <= '0;
			end else begin
				c_s[i] <= ci;
			end
		end

		always_ff @(posedge clk) begin
			if (!zi[CW-1]) begin
				x_s[i] <= xi - dx;
				y_s[i] <= yi + dy;
				z_s[i] <= zi - at;
			end else begin
				x_s[i] <= xi + dx;
				y_s[i] <= yi - dy;
				z_s[i] <= zi + at;
			end
		end
	end

	assign ctl_out = c_s[STAGES-1];
	assign cos_out = x_s[STAGES-1];
	assign sin_out = y_s[STAGES-1];

endmodule

/* sv/cbpg_scale.sv */
// Radius scaling, center offset with quadrant sign/swap, and saturation.
module cbpg_scale (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cbpg_pkg::ctl_t                      ctl_in,
	input  logic signed [cbpg_pkg::CW-1:0]      cos_in,
	input  logic signed [cbpg_pkg::CW-1:0]      sin_in,
	input  logic signed [cbpg_pkg::COORD_W-1:0] origin_x,
	input  logic signed [cbpg_pkg::COORD_W-1:0] origin_y,
	input  logic [cbpg_pkg::RAD_W-1:0]          radius,
	output cbpg_pkg::ctl_t                      ctl_out,
	output logic signed [cbpg_pkg::COORD_W-1:0] point_x,
	output logic signed [cbpg_pkg::COORD_W-1:0] point_y
);
	import cbpg_pkg::*;

	localparam logic signed [MUL_W-1:0] RND = 64'sd536870912;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sd2147483648);

	ctl_t                     ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [TRIG_W-1:0] c_s1, s_s1;
	logic signed [MUL_W-1:0]  pc_s2, ps_s2;
	logic signed [TERM_W-1:0] tc_s3, ts_s3;
	logic signed [COORD_W-1:0] px_s4, py_s4;

	logic signed [CW-1:0]      c_neg;
	logic signed [COORD_W-1:0] rad_sg;
	logic signed [TERM_W-1:0]  tx, ty;
	logic                      add_x, add_y;
	logic signed [SUM_W-1:0]   sx, sy;

	function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		priority if (v > SAT_HI) begin
			r = SAT_HI[COORD_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	assign c_neg  = ctl_in.neg ? -cos_in : cos_in;
	assign rad_sg = $signed({1'b0, radius});

	always_comb begin
		unique case (ctl_s3.quad)
			2'd0: begin
				tx = ts_s3; ty = tc_s3; add_x = 1'b1; add_y = 1'b0;
			end
			2'd1: begin
				tx = tc_s3; ty = ts_s3; add_x = 1'b1; add_y = 1'b1;
			end
			2'd2: begin
				tx = ts_s3; ty = tc_s3; add_x = 1'b0; add_y = 1'b1;
			end
			default: begin
				tx = tc_s3; ty = ts_s3; add_x = 1'b0; add_y = 1'b0;
			end
		endcase
		sx = add_x ? (SUM_W'(origin_x) + SUM_W'(tx)) : (SUM_W'(origin_x) - SUM_W'(tx));
		sy = add_y ? (SUM_W'(origin_y) + SUM_W'(ty)) : (SUM_W'(origin_y) - SUM_W'(ty));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		c_s1  <= TRIG_W'(c_neg);
		s_s1  <= TRIG_W'(sin_in);
		pc_s2 <= MUL_W'(rad_sg * c_s1);
		ps_s2 <= MUL_W'(rad_sg * s_s1);
		tc_s3 <= TERM_W'((pc_s2 + RND) >>> 30);
		ts_s3 <= TERM_W'((ps_s2 + RND) >>> 30);
		px_s4 <= sat(sx);
		py_s4 <= sat(sy);
	end

	assign ctl_out = ctl_s4;
	assign point_x = px_s4;
	assign point_y = py_s4;

endmodule

/* sv/cbpg_checker.sv */
// Port-level checker for the circle boundary point generator, with its bind.
module cbpg_checker #(
	parameter int unsigned CORDIC_STAGES = cbpg_pkg::CORDIC_STAGES_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic signed [cbpg_pkg::COORD_W-1:0] point_x,
	input logic signed [cbpg_pkg::COORD_W-1:0] point_y,
	input logic                                index_error,
	input logic                                cfg_valid,
	input logic                                cfg_ready
);
	import cbpg_pkg::*;

	localparam int unsigned LAT = FIXED_LAT + CORDIC_STAGES;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction produced no result");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching command");

	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({point_x, point_y, index_error}))
		else $error("result payload unknown");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind circle_boundary_point_generator_top cbpg_checker #(
	.CORDIC_STAGES (CORDIC_STAGES)
) u_cbpg_checker (.*);
